>>> sv/ror_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring of records package
// Sizes, request codes, shared types and slot helpers for the record ring.
// ----------------------------------------------------------------------------
package ror_pkg;

  localparam int SLOTS       = 10;
  localparam int LENGTH_BITS = 16;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int HANDLE_W = 32;
  localparam int RLEN_W   = 16;
  localparam int POS_W    = 20;
  localparam int IDX_W    = 16;
  localparam int CMP_W    = ((POS_W > LENGTH_BITS) ? POS_W : LENGTH_BITS) + 1;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic                   en;
    logic [HANDLE_W-1:0]    handle;
    logic [LENGTH_BITS-1:0] length;
  } wr_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]    handle;
    logic [LENGTH_BITS-1:0] length;
  } rec_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic [IDX_W-1:0]    index;
  } res_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] fit_len(input logic [RLEN_W-1:0] x);
    logic [47:0] wide;
    wide    = {32'b0, x};
    fit_len = wide[LENGTH_BITS-1:0];
  endfunction

endpackage

>>> sv/ror_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record store
// Handle and length registers of the ring with write, oldest and full state.
// ----------------------------------------------------------------------------
module ror_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ror_pkg::wr_t               wr_i,
  input  logic [ror_pkg::SLOT_W-1:0] rd_slot_i,
  output ror_pkg::rec_t              rd_o,
  output logic [ror_pkg::SLOT_W-1:0] oldest_o
);
  import ror_pkg::*;

  logic [HANDLE_W-1:0]    handle_q [SLOTS];
  logic [LENGTH_BITS-1:0] length_q [SLOTS];
  logic [SLOT_W-1:0]      wr_slot_q, wr_slot_d;
  logic [SLOT_W-1:0]      oldest_q, oldest_d;
  logic                   full_q, full_d;

  always_comb begin
    wr_slot_d = wr_slot_q;
    oldest_d  = oldest_q;
    full_d    = full_q;
    if (wr_i.en) begin
      wr_slot_d = next_slot(wr_slot_q);
      if (full_q) begin
        oldest_d = next_slot(oldest_q);
      end
      full_d = full_q | (next_slot(wr_slot_q) == oldest_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        handle_q[i] <= '0;
        length_q[i] <= '0;
      end
      wr_slot_q <= '0;
      oldest_q  <= '0;
      full_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        handle_q[wr_slot_q] <= wr_i.handle;
        length_q[wr_slot_q] <= wr_i.length;
      end
      wr_slot_q <= wr_slot_d;
      oldest_q  <= oldest_d;
      full_q    <= full_d;
    end
  end

  assign rd_o.handle = handle_q[rd_slot_i];
  assign rd_o.length = length_q[rd_slot_i];
  assign oldest_o    = oldest_q;

`ifndef ASSERT_OFF
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q) else $error("Full flag cleared after the ring filled.");

  a_oldest_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_q |-> (oldest_q == '0)) else $error("Oldest slot moved before the ring filled.");

  a_full_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (wr_slot_q == oldest_q)) else $error("Full ring with split positions.");
`endif

endmodule

>>> sv/ror_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request sequencer
// Takes add and find words and walks the ring with one subtract-compare unit.
// ----------------------------------------------------------------------------
module ror_walker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [ror_pkg::HANDLE_W-1:0] record_handle_i,
  input  logic [ror_pkg::RLEN_W-1:0]   record_length_i,
  input  logic [ror_pkg::POS_W-1:0]    byte_position_i,
  output ror_pkg::wr_t                 wr_o,
  output logic [ror_pkg::SLOT_W-1:0]   rd_slot_o,
  input  ror_pkg::rec_t                rd_i,
  input  logic [ror_pkg::SLOT_W-1:0]   oldest_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output ror_pkg::res_t                res_o
);
  import ror_pkg::*;

  state_e            state_q, state_d;
  logic [POS_W-1:0]  rem_q, rem_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  res_t              res_q, res_d;
  logic [CMP_W-1:0]  diff;
  logic              hit_now;
  logic              last;

  assign diff    = CMP_W'(rem_q) - CMP_W'(rd_i.length);
  assign hit_now = diff[CMP_W-1];
  assign last    = (cnt_q == SLOT_W'(SLOTS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (req_type_i == REQ_FIND) ? ST_WALK : ST_RESULT;
        end
      end
      ST_WALK: begin
        if (hit_now || last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_RESULT);
    rd_slot_o   = slot_q;
    wr_o.en     = (state_q == ST_IDLE) && in_valid_i && (req_type_i == REQ_ADD);
    wr_o.handle = record_handle_i;
    wr_o.length = fit_len(record_length_i);
    res_o       = res_q;
  end

  always_comb begin
    rem_d  = rem_q;
    slot_d = slot_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    if ((state_q == ST_IDLE) && in_valid_i) begin
      rem_d  = byte_position_i;
      slot_d = oldest_i;
      cnt_d  = '0;
      res_d  = '0;
    end else if (state_q == ST_WALK) begin
      if (hit_now) begin
        res_d.hit    = 1'b1;
        res_d.handle = rd_i.handle;
        res_d.index  = rem_q[IDX_W-1:0];
      end else if (!last) begin
        rem_d  = diff[POS_W-1:0];
        slot_d = next_slot(slot_q);
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

`ifndef ASSERT_OFF
  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_ADD)) |=>
      (state_q == ST_RESULT) && !res_q.hit) else $error("Add did not give an empty result.");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && last && !hit_now) |=>
      (state_q == ST_RESULT) && !res_q.hit) else $error("Full walk did not end in a miss.");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_q.hit) |-> (res_q.handle == '0) && (res_q.index == '0))
    else $error("Miss result carries a handle or an index.");
`endif

endmodule

>>> sv/ring_of_records_with_offset_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring of records with offset lookup
// Record ring with add and byte-offset find requests, one result per request.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Word
//  in        in_valid_i/in_ready_o   req_type, record_handle, record_length,
//                                    byte_position
//  out       out_valid_o/out_ready_i hit, hit_handle, index_in_record
//
// An add goes from acceptance straight to its result; a find walks the records
// from the oldest through the subtract-compare unit until a hit or the last one.
// The input is held off while a request is in work or its result cannot move
// into the output register. Reset clears all records to zero length at once.
// ----------------------------------------------------------------------------
module ring_of_records_with_offset_lookup_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [ror_pkg::HANDLE_W-1:0] record_handle_i,
  input  logic [ror_pkg::RLEN_W-1:0]   record_length_i,
  input  logic [ror_pkg::POS_W-1:0]    byte_position_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [ror_pkg::HANDLE_W-1:0] hit_handle_o,
  output logic [ror_pkg::IDX_W-1:0]    index_in_record_o
);
  import ror_pkg::*;

  wr_t               wr;
  rec_t              rd;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] oldest;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  ror_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_slot_i (rd_slot),
    .rd_o      (rd),
    .oldest_o  (oldest)
  );

  ror_walker u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .record_handle_i (record_handle_i),
    .record_length_i (record_length_i),
    .byte_position_i (byte_position_i),
    .wr_o            (wr),
    .rd_slot_o       (rd_slot),
    .rd_i            (rd),
    .oldest_i        (oldest),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = out_q.hit;
  assign hit_handle_o      = out_q.handle;
  assign index_in_record_o = out_q.index;

endmodule

>>> sim/tb_ring_of_records_with_offset_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the ring of records with offset lookup
// Sends add and find words with random gaps on both channels, predicts each
// result from a local copy of the record ring and compares it field by field.
// ----------------------------------------------------------------------------
module tb_ring_of_records_with_offset_lookup_core;
  import ror_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                req_type_i;
  logic [HANDLE_W-1:0] record_handle_i;
  logic [RLEN_W-1:0]   record_length_i;
  logic [POS_W-1:0]    byte_position_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                hit_o;
  logic [HANDLE_W-1:0] hit_handle_o;
  logic [IDX_W-1:0]    index_in_record_o;

  logic [HANDLE_W-1:0]    ring_handle [SLOTS];
  logic [LENGTH_BITS-1:0] ring_length [SLOTS];
  int unsigned            ring_write;
  int unsigned            ring_oldest;
  logic                   ring_full_flag;

  res_t        expected_results[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  ring_of_records_with_offset_lookup_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .record_handle_i   (record_handle_i),
    .record_length_i   (record_length_i),
    .byte_position_i   (byte_position_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hit_o             (hit_o),
    .hit_handle_o      (hit_handle_o),
    .index_in_record_o (index_in_record_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned bytes_before(input int unsigned walk_pos);
    int unsigned sum;
    sum = 0;
    for (int unsigned n = 0; n < walk_pos; n++) begin
      sum += ring_length[(ring_oldest + n) % SLOTS];
    end
    return sum;
  endfunction

  function automatic res_t predict_lookup(input logic req, input logic [HANDLE_W-1:0] h,
                                          input logic [RLEN_W-1:0] len,
                                          input logic [POS_W-1:0] pos);
    res_t        res;
    int unsigned base;
    int unsigned slot;
    logic        found;
    res   = '0;
    base  = 0;
    found = 1'b0;
    if (req == REQ_ADD) begin
      ring_handle[ring_write] = h;
      ring_length[ring_write] = len[LENGTH_BITS-1:0];
      if (ring_full_flag) ring_oldest = (ring_oldest + 1) % SLOTS;
      ring_write = (ring_write + 1) % SLOTS;
      if (ring_write == ring_oldest) ring_full_flag = 1'b1;
    end else begin
      slot = ring_oldest;
      for (int n = 0; n < SLOTS; n++) begin
        if (!found && pos >= base && pos < base + ring_length[slot]) begin
          found      = 1'b1;
          res.hit    = 1'b1;
          res.handle = ring_handle[slot];
          res.index  = IDX_W'(pos - base);
        end
        base += ring_length[slot];
        slot = (slot + 1) % SLOTS;
      end
    end
    return res;
  endfunction

  task automatic send_word(input logic req, input logic [HANDLE_W-1:0] h,
                           input logic [RLEN_W-1:0] len, input logic [POS_W-1:0] pos);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    record_handle_i <= h;
    record_length_i <= len;
    byte_position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_lookup(req, h, len, pos));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_ring();
    send_word(REQ_FIND, 32'h0, 16'h0, 20'h0);
    send_word(REQ_FIND, 32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF);
    wait_drained();
  endtask

  task automatic test_record_extremes();
    send_word(REQ_ADD, 32'h0000_0000, 16'd0, 20'h0);
    send_word(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF);
    send_word(REQ_ADD, 32'h1234_5678, 16'd1, 20'h0);
    send_word(REQ_ADD, 32'hA5A5_5A5A, 16'd0, 20'h0);
    send_word(REQ_ADD, 32'h0BAD_F00D, 16'd3, 20'h0);
    send_word(REQ_FIND, 32'h0, 16'h0, 20'd0);
    send_word(REQ_FIND, 32'h0, 16'h0, 20'd65534);
    send_word(REQ_FIND, 32'h0, 16'h0, 20'd65535);
    send_word(REQ_FIND, 32'h0, 16'h0, 20'd65536);
    send_word(REQ_FIND, 32'h0, 16'h0, 20'd65538);
    send_word(REQ_FIND, 32'h0, 16'h0, 20'd65539);
    wait_drained();
  endtask

  task automatic test_ring_overwrite();
    int unsigned total;
    for (int i = 0; i < 7; i++) begin
      send_word(REQ_ADD, HANDLE_W'(32'hC000_0000 + i), 16'd2, 20'h0);
    end
    total = bytes_before(SLOTS);
    send_word(REQ_FIND, 32'h0, 16'h0, 20'd0);
    send_word(REQ_FIND, 32'h0, 16'h0, POS_W'(total - 1));
    send_word(REQ_FIND, 32'h0, 16'h0, POS_W'(total));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned words, input int unsigned s_idle,
                                     input int unsigned r_idle);
    logic [RLEN_W-1:0] len;
    logic [POS_W-1:0]  pos;
    int unsigned       pick;
    int unsigned       k;
    int unsigned       start;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int unsigned i = 0; i < words; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 40) begin
        if (pick < 10) len = '0;
        else if (pick < 70) len = RLEN_W'($urandom_range(1, 40));
        else if (pick < 90) len = RLEN_W'($urandom);
        else len = {RLEN_W{1'b1}};
        send_word(REQ_ADD, $urandom, len, POS_W'($urandom));
      end else begin
        if (pick < 65) begin
          pos = POS_W'($urandom_range(0, bytes_before(SLOTS) + 2));
        end else if (pick < 85) begin
          k     = $urandom_range(0, SLOTS - 1);
          start = bytes_before(k);
          case ($urandom_range(0, 2))
            0: pos = POS_W'(start);
            1: pos = POS_W'(start + ring_length[(ring_oldest + k) % SLOTS]);
            default: pos = POS_W'(start - 1);
          endcase
        end else begin
          pos = POS_W'($urandom);
        end
        send_word(REQ_FIND, $urandom, RLEN_W'($urandom), pos);
      end
    end
    wait_drained();
  endtask

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word hit=%0b handle=%h index=%h", $realtime,
                   hit_o, hit_handle_o, index_in_record_o);
        end else begin
          res_t want;
          want = expected_results.pop_front();
          if (hit_o !== want.hit) begin
            mismatch_count++;
            $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, hit_o);
          end
          if (hit_handle_o !== want.handle) begin
            mismatch_count++;
            $display("%0t: hit_handle expected %h actual %h", $realtime, want.handle,
                     hit_handle_o);
          end
          if (index_in_record_o !== want.index) begin
            mismatch_count++;
            $display("%0t: index_in_record expected %h actual %h", $realtime, want.index,
                     index_in_record_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    req_type_i      <= REQ_ADD;
    record_handle_i <= '0;
    record_length_i <= '0;
    byte_position_i <= '0;
    send_idle_pct   = 38;
    recv_idle_pct   = 71;
    ring_write      = 0;
    ring_oldest     = 0;
    ring_full_flag  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      ring_handle[i] = '0;
      ring_length[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_empty_ring();
    test_record_extremes();
    test_ring_overwrite();
    test_random_traffic(350, 38, 71);
    test_random_traffic(350, 71, 38);
    test_random_traffic(350, 0, 0);

    repeat (3 * SLOTS) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
